>>> rtl/gatr_pkg.sv
// Package for the gate actuator timeout and retry controller.
// Holds sizes, operation and register codes, the compartment state type and
// the structs between the modules. No dependencies.
package gatr_pkg;

   // Number of compartment controllers, 1 to 15.
   localparam int COMPARTMENTS = 10;
   // Masks and switch fields cover compartments 1 to 10 only.
   localparam int MASK_BITS    = 10;
   // Wide enough to compare compartment numbers up to 32.
   localparam int NUM_W        = 6;

   localparam int OP_W         = 2;
   localparam int COMP_W       = 4;
   localparam int ACTIVE_W     = 4;
   localparam int TIMEOUT_W    = 16;
   localparam int RETRY_W      = 3;
   localparam int STATE_CODE_W = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = ACTIVE_W'(10);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000);
   localparam logic [RETRY_W-1:0]   RETRY_RESET   = RETRY_W'(3);

   typedef logic [MASK_BITS-1:0] mask_type;

   typedef enum logic [OP_W-1:0] {
      OP_OPEN  = 2'd0,
      OP_CLOSE = 2'd1,
      OP_TICK  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ACTIVE_COUNT  = 2'd0,
      REG_TIMEOUT_TICKS = 2'd1,
      REG_RETRY_LIMIT   = 2'd2
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_CLOSED  = 5'b00001,
      ST_OPENING = 5'b00010,
      ST_OPEN    = 5'b00100,
      ST_CLOSING = 5'b01000,
      ST_ERROR   = 5'b10000
   } gate_state_type;

   localparam logic [STATE_CODE_W-1:0] CODE_CLOSED  = 3'd0;
   localparam logic [STATE_CODE_W-1:0] CODE_OPENING = 3'd1;
   localparam logic [STATE_CODE_W-1:0] CODE_OPEN    = 3'd2;
   localparam logic [STATE_CODE_W-1:0] CODE_CLOSING = 3'd3;
   localparam logic [STATE_CODE_W-1:0] CODE_ERROR   = 3'd4;

   // Configuration as seen by the compartment controllers.
   typedef struct packed {
      logic [NUM_W-1:0]     eff_active;
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [RETRY_W-1:0]   retry_limit;
   } cfg_type;

   // One processing step as seen by one compartment.
   typedef struct packed {
      logic   step;
      op_type op;
      logic   sel;
      logic   active;
      logic   open_sw;
      logic   closed_sw;
   } cell_cmd_type;

   // Values a compartment will hold after the current step.
   typedef struct packed {
      gate_state_type state;
      logic           servo;
      logic           retry;
      logic           accept;
   } cell_stat_type;

   function automatic logic [STATE_CODE_W-1:0] state_code(input gate_state_type s);
      logic [STATE_CODE_W-1:0] code;
      case (s)
         ST_CLOSED:  code = CODE_CLOSED;
         ST_OPENING: code = CODE_OPENING;
         ST_OPEN:    code = CODE_OPEN;
         ST_CLOSING: code = CODE_CLOSING;
         ST_ERROR:   code = CODE_ERROR;
         default:    code = CODE_CLOSED;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/gatr_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on gatr_pkg.
interface gatr_req_if;
   import gatr_pkg::*;
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic [COMP_W-1:0]    compartment;
   logic [MASK_BITS-1:0] open_switches;
   logic [MASK_BITS-1:0] closed_switches;
   modport source (output valid, op, compartment, open_switches, closed_switches,
                   input ready);
   modport sink   (input valid, op, compartment, open_switches, closed_switches,
                   output ready);
endinterface

interface gatr_rsp_if;
   import gatr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [STATE_CODE_W-1:0] addressed_state;
   logic                    accepted;
   logic [MASK_BITS-1:0]    servo_open_mask;
   logic [MASK_BITS-1:0]    moving_mask;
   logic [MASK_BITS-1:0]    error_mask;
   logic [MASK_BITS-1:0]    retry_mask;
   modport source (output valid, addressed_state, accepted, servo_open_mask,
                   moving_mask, error_mask, retry_mask, input ready);
   modport sink   (input valid, addressed_state, accepted, servo_open_mask,
                   moving_mask, error_mask, retry_mask, output ready);
endinterface

interface gatr_csr_if;
   import gatr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/gatr_csr.sv
// Configuration registers: active count, move timeout and retry limit.
// Depends on gatr_pkg and gatr_if.
module gatr_csr (
   input  logic             clock,
   input  logic             reset,
   gatr_csr_if.sink         csr_chan,
   output gatr_pkg::cfg_type cfg
);
   import gatr_pkg::*;

   logic [ACTIVE_W-1:0]  active_count_ff;
   logic [TIMEOUT_W-1:0] timeout_ticks_ff;
   logic [RETRY_W-1:0]   retry_limit_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff  <= ACTIVE_RESET;
         timeout_ticks_ff <= TIMEOUT_RESET;
         retry_limit_ff   <= RETRY_RESET;
      end else if (csr_chan.valid) begin
         case (reg_index_type'(csr_chan.index))
            REG_ACTIVE_COUNT:  active_count_ff  <= csr_chan.data[ACTIVE_W-1:0];
            REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_chan.data[TIMEOUT_W-1:0];
            REG_RETRY_LIMIT:   retry_limit_ff   <= csr_chan.data[RETRY_W-1:0];
            default: ;
         endcase
      end
   end

   // A count above the number of controllers acts as the full set.
   always_comb begin
      if (NUM_W'(active_count_ff) > NUM_W'(COMPARTMENTS)) begin
         cfg.eff_active = NUM_W'(COMPARTMENTS);
      end else begin
         cfg.eff_active = NUM_W'(active_count_ff);
      end
      cfg.timeout_ticks = timeout_ticks_ff;
      cfg.retry_limit   = retry_limit_ff;
   end
endmodule

>>> rtl/gatr_cell.sv
// Controller of one compartment: gate state, move timer, retry count, servo.
// Depends on gatr_pkg.
module gatr_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  gatr_pkg::cfg_type       cfg,
   input  gatr_pkg::cell_cmd_type  cmd,
   output gatr_pkg::cell_stat_type stat
);
   import gatr_pkg::*;

   gate_state_type       state_ff, state_in;
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;
   logic [RETRY_W-1:0]   retries_ff, retries_in;
   logic                 servo_ff, servo_in;
   logic                 retry, accept, moving;

   assign moving = (state_ff == ST_OPENING) || (state_ff == ST_CLOSING);

   always_comb begin
      state_in   = state_ff;
      elapsed_in = elapsed_ff;
      retries_in = retries_ff;
      servo_in   = servo_ff;
      retry      = 1'b0;
      accept     = 1'b0;
      case (cmd.op)
         OP_OPEN: begin
            if (cmd.sel && (state_ff == ST_CLOSED || state_ff == ST_ERROR)) begin
               state_in   = ST_OPENING;
               elapsed_in = '0;
               retries_in = '0;
               servo_in   = 1'b1;
               accept     = 1'b1;
            end
         end
         OP_CLOSE: begin
            if (cmd.sel && (state_ff == ST_OPEN || state_ff == ST_ERROR)) begin
               state_in   = ST_CLOSING;
               elapsed_in = '0;
               retries_in = '0;
               servo_in   = 1'b0;
               accept     = 1'b1;
            end
         end
         OP_TICK: begin
            if (cmd.active && moving) begin
               if (elapsed_ff >= cfg.timeout_ticks) begin
                  // Stuck move: restart the timer while retries remain.
                  if (retries_ff < cfg.retry_limit) begin
                     retries_in = retries_ff + RETRY_W'(1);
                     elapsed_in = '0;
                     retry      = 1'b1;
                  end else begin
                     state_in = ST_ERROR;
                  end
               end else begin
                  elapsed_in = elapsed_ff + TIMEOUT_W'(1);
                  if (state_ff == ST_OPENING && cmd.open_sw) begin
                     state_in = ST_OPEN;
                  end else if (state_ff == ST_CLOSING && cmd.closed_sw) begin
                     state_in = ST_CLOSED;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLOSED;
         elapsed_ff <= '0;
         retries_ff <= '0;
         servo_ff   <= 1'b0;
      end else if (cmd.step) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         retries_ff <= retries_in;
         servo_ff   <= servo_in;
      end
   end

   assign stat.state  = state_in;
   assign stat.servo  = servo_in;
   assign stat.retry  = retry;
   assign stat.accept = accept;
endmodule

>>> rtl/gate_actuator_timeout_retry_fsm_core.sv
// Gate actuator controller with move timeout and retry, top level.
// The request is held in the request register, then the response word in the response
// register, where it waits until it is taken. Throughput: one word per cycle while the
// response side takes words; a stalled response holds both stages.
// Synchronous active-high reset: every compartment closed, timers and retry
// counts zero, servos closed, registers at defaults. Depends on gatr_pkg,
// gatr_if, gatr_csr and gatr_cell.
module gate_actuator_timeout_retry_fsm_core (
   input  logic       clock,
   input  logic       reset,
   gatr_req_if.sink   req_chan,
   gatr_rsp_if.source rsp_chan,
   gatr_csr_if.sink   csr_chan
);
   import gatr_pkg::*;

   cfg_type cfg;

   logic                 s1_valid_ff, s1_valid_in;
   op_type               s1_op_ff;
   logic [COMP_W-1:0]    s1_comp_ff;
   mask_type             s1_osw_ff;
   mask_type             s1_csw_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATE_CODE_W-1:0] rsp_state_ff, rsp_state_in;
   logic                    rsp_accepted_ff, rsp_accepted_in;
   mask_type                rsp_servo_ff, rsp_servo_in;
   mask_type                rsp_moving_ff, rsp_moving_in;
   mask_type                rsp_error_ff, rsp_error_in;
   mask_type                rsp_retry_ff, rsp_retry_in;

   logic          advance, addressed;
   cell_cmd_type  cmd  [COMPARTMENTS];
   cell_stat_type stat [COMPARTMENTS];

   gatr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // The request stage moves on whenever the response register is free or drained.
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign s1_valid_in    = req_chan.valid || (s1_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_chan.ready);

   assign addressed = (s1_comp_ff != '0) && (NUM_W'(s1_comp_ff) <= cfg.eff_active);

   for (genvar i = 0; i < COMPARTMENTS; i++) begin : g_cell
      logic osw_bit, csw_bit;
      if (i < MASK_BITS) begin : g_sw
         assign osw_bit = s1_osw_ff[i];
         assign csw_bit = s1_csw_ff[i];
      end else begin : g_no_sw
         assign osw_bit = 1'b0;
         assign csw_bit = 1'b0;
      end
      always_comb begin
         cmd[i].step      = advance;
         cmd[i].op        = s1_op_ff;
         cmd[i].sel       = addressed && (NUM_W'(s1_comp_ff) == NUM_W'(i + 1));
         cmd[i].active    = NUM_W'(i) < cfg.eff_active;
         cmd[i].open_sw   = osw_bit;
         cmd[i].closed_sw = csw_bit;
      end
      gatr_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg),
         .cmd   (cmd[i]),
         .stat  (stat[i])
      );
   end

   always_comb begin
      rsp_state_in    = '0;
      rsp_accepted_in = 1'b0;
      rsp_servo_in    = '0;
      rsp_moving_in   = '0;
      rsp_error_in    = '0;
      rsp_retry_in    = '0;
      for (int i = 0; i < COMPARTMENTS; i++) begin
         if (cmd[i].sel) begin
            rsp_state_in = rsp_state_in | state_code(stat[i].state);
         end
         rsp_accepted_in = rsp_accepted_in | stat[i].accept;
         if (i < MASK_BITS) begin
            rsp_servo_in[i]  = stat[i].servo;
            rsp_moving_in[i] = (stat[i].state == ST_OPENING) ||
                               (stat[i].state == ST_CLOSING);
            rsp_error_in[i]  = stat[i].state == ST_ERROR;
            rsp_retry_in[i]  = stat[i].retry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_op_ff   <= req_chan.op;
         s1_comp_ff <= req_chan.compartment;
         s1_osw_ff  <= req_chan.open_switches;
         s1_csw_ff  <= req_chan.closed_switches;
      end
      if (advance) begin
         rsp_state_ff    <= rsp_state_in;
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_servo_ff    <= rsp_servo_in;
         rsp_moving_ff   <= rsp_moving_in;
         rsp_error_ff    <= rsp_error_in;
         rsp_retry_ff    <= rsp_retry_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.addressed_state = rsp_state_ff;
   assign rsp_chan.accepted        = rsp_accepted_ff;
   assign rsp_chan.servo_open_mask = rsp_servo_ff;
   assign rsp_chan.moving_mask     = rsp_moving_ff;
   assign rsp_chan.error_mask      = rsp_error_ff;
   assign rsp_chan.retry_mask      = rsp_retry_ff;
endmodule

>>> tb/testbench.sv
// Self-checking testbench for gate_actuator_timeout_retry_fsm_core.
// Sends commands, ticks and queries, predicts every response word in-bench and
// checks it field by field. Depends on gatr_pkg, gatr_if and the core RTL.
module testbench;
   import gatr_pkg::*;

   typedef struct packed {
      logic [STATE_CODE_W-1:0] addressed_state;
      logic                    accepted;
      mask_type                servo_open_mask;
      mask_type                moving_mask;
      mask_type                error_mask;
      mask_type                retry_mask;
   } gate_report_type;

   typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_PATTERN, DRAIN_SLOW} drain_mode_type;

   localparam int REPORT_LIMIT  = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int RUN_LIMIT     = 5000000;
   localparam int PHASES        = 9;

   logic clock = 1'b0;
   logic reset;

   gatr_req_if req_chan();
   gatr_rsp_if rsp_chan();
   gatr_csr_if csr_chan();

   gate_actuator_timeout_retry_fsm_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // In-bench copy of the compartment controllers and their registers.
   logic [STATE_CODE_W-1:0] gate_code   [COMPARTMENTS];
   logic [TIMEOUT_W-1:0]    move_ticks  [COMPARTMENTS];
   logic [RETRY_W-1:0]      retry_count [COMPARTMENTS];
   logic                    servo_cmd   [COMPARTMENTS];
   logic [ACTIVE_W-1:0]     cfg_active;
   logic [TIMEOUT_W-1:0]    cfg_timeout;
   logic [RETRY_W-1:0]      cfg_retry;

   gate_report_type expected_reports[$];

   int n_sent       = 0;
   int n_checked    = 0;
   int n_mismatch   = 0;
   int n_moves      = 0;
   int n_retries    = 0;
   int n_settings   = 0;
   int burst_left   = 0;
   bit gaps_on      = 1'b1;
   int hold_asked   = 0;
   int hold_served  = 0;
   int hold_left    = 0;
   int mode_left    = 0;
   drain_mode_type drain_mode = DRAIN_FREE;

   function automatic int active_limit();
      return (cfg_active > COMPARTMENTS) ? COMPARTMENTS : int'(cfg_active);
   endfunction

   function automatic void start_gate(int k, logic to_open);
      gate_code[k]   = to_open ? CODE_OPENING : CODE_CLOSING;
      move_ticks[k]  = '0;
      retry_count[k] = '0;
      servo_cmd[k]   = to_open;
   endfunction

   // Applies one request word to the in-bench controllers and returns the
   // response word the block must produce for it.
   function automatic gate_report_type step_gates(op_type op, logic [COMP_W-1:0] comp,
                                                  mask_type osw, mask_type csw);
      gate_report_type r;
      int act;
      bit hit;
      int k;
      int i;
      logic [STATE_CODE_W-1:0] s;
      act = active_limit();
      hit = (comp >= 1) && (comp <= act);
      k = hit ? int'(comp) - 1 : 0;
      r = '0;
      case (op)
         OP_OPEN: begin
            if (hit && (gate_code[k] == CODE_CLOSED || gate_code[k] == CODE_ERROR)) begin
               start_gate(k, 1'b1);
               r.accepted = 1'b1;
            end
         end
         OP_CLOSE: begin
            if (hit && (gate_code[k] == CODE_OPEN || gate_code[k] == CODE_ERROR)) begin
               start_gate(k, 1'b0);
               r.accepted = 1'b1;
            end
         end
         OP_TICK: begin
            for (i = 0; i < act; i++) begin
               s = gate_code[i];
               if (s == CODE_OPENING || s == CODE_CLOSING) begin
                  // The timeout test uses the count from before this tick.
                  if (move_ticks[i] >= cfg_timeout) begin
                     if (retry_count[i] < cfg_retry) begin
                        retry_count[i] = retry_count[i] + 1'b1;
                        move_ticks[i]  = '0;
                        if (i < MASK_BITS) r.retry_mask[i] = 1'b1;
                     end else begin
                        gate_code[i] = CODE_ERROR;
                     end
                  end else begin
                     move_ticks[i] = move_ticks[i] + 1'b1;
                     if (s == CODE_OPENING && i < MASK_BITS && osw[i])
                        gate_code[i] = CODE_OPEN;
                     else if (s == CODE_CLOSING && i < MASK_BITS && csw[i])
                        gate_code[i] = CODE_CLOSED;
                  end
               end
            end
         end
         default: ;
      endcase
      for (i = 0; i < COMPARTMENTS && i < MASK_BITS; i++) begin
         r.servo_open_mask[i] = servo_cmd[i];
         r.moving_mask[i]     = (gate_code[i] == CODE_OPENING || gate_code[i] == CODE_CLOSING);
         r.error_mask[i]      = (gate_code[i] == CODE_ERROR);
      end
      r.addressed_state = hit ? gate_code[k] : CODE_CLOSED;
      return r;
   endfunction

   // Sends one request word. The sender runs in bursts with random gaps.
   task automatic send_word(op_type op, logic [COMP_W-1:0] comp, mask_type osw,
                            mask_type csw);
      gate_report_type r;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_chan.valid           <= 1'b1;
      req_chan.op              <= op;
      req_chan.compartment     <= comp;
      req_chan.open_switches   <= osw;
      req_chan.closed_switches <= csw;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      r = step_gates(op, comp, osw, csw);
      expected_reports.push_back(r);
      n_sent++;
      if (r.accepted) n_moves++;
      if (r.retry_mask != '0) n_retries++;
   endtask

   // Holds the request side idle until every response word has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      case (idx)
         REG_ACTIVE_COUNT:  cfg_active  = value[ACTIVE_W-1:0];
         REG_TIMEOUT_TICKS: cfg_timeout = value[TIMEOUT_W-1:0];
         REG_RETRY_LIMIT:   cfg_retry   = value[RETRY_W-1:0];
         default: ;
      endcase
   endtask

   // Writes all three registers once the block is idle. Unused upper data
   // bits carry random values, which the block must ignore.
   task automatic apply_settings(int active, int timeout, int retries);
      logic [CSR_DATA_W-1:0] noise;
      wait_drained();
      noise = CSR_DATA_W'($urandom);
      write_reg(REG_ACTIVE_COUNT, {noise[CSR_DATA_W-1:ACTIVE_W], active[ACTIVE_W-1:0]});
      write_reg(REG_TIMEOUT_TICKS, timeout[TIMEOUT_W-1:0]);
      noise = CSR_DATA_W'($urandom);
      write_reg(REG_RETRY_LIMIT, {noise[CSR_DATA_W-1:RETRY_W], retries[RETRY_W-1:0]});
      csr_chan.valid <= 1'b0;
      n_settings++;
   endtask

   // Higher density sets more limit switches per tick.
   function automatic mask_type switch_pattern(int density);
      mask_type m;
      case (density)
         0:       m = '0;
         1:       m = MASK_BITS'($urandom & $urandom & $urandom & $urandom);
         2:       m = MASK_BITS'($urandom & $urandom);
         3:       m = MASK_BITS'($urandom);
         default: m = '1;
      endcase
      return m;
   endfunction

   task automatic run_random(int count, int density);
      op_type op;
      logic [COMP_W-1:0] comp;
      int act;
      int pick;
      int n;
      int j;
      int k;
      int first;
      int dens;
      for (n = 0; n < count; n++) begin
         act = active_limit();
         pick = $urandom_range(0, 99);
         if (pick < 50) op = OP_TICK;
         else if (pick < 70) op = OP_OPEN;
         else if (pick < 90) op = OP_CLOSE;
         else op = OP_QUERY;
         if (act > 0 && $urandom_range(0, 9) != 0) comp = COMP_W'($urandom_range(1, act));
         else comp = COMP_W'($urandom_range(0, 15));
         // Most commands go to a compartment whose state allows them.
         if ((op == OP_OPEN || op == OP_CLOSE) && act > 0 && $urandom_range(0, 9) < 7) begin
            first = $urandom_range(0, act - 1);
            for (j = 0; j < act; j++) begin
               k = (first + j) % act;
               if ((op == OP_OPEN && (gate_code[k] == CODE_CLOSED || gate_code[k] == CODE_ERROR))
                   || (op == OP_CLOSE && (gate_code[k] == CODE_OPEN ||
                                          gate_code[k] == CODE_ERROR))) begin
                  comp = COMP_W'(k + 1);
                  break;
               end
            end
         end
         dens = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : density;
         send_word(op, comp, switch_pattern(dens), switch_pattern(dens));
      end
   endtask

   task automatic test_commands();
      send_word(OP_QUERY, 0, '0, '0);
      send_word(OP_QUERY, 15, '1, '1);
      send_word(OP_OPEN, 1, '0, '0);
      send_word(OP_OPEN, 1, '0, '0);
      send_word(OP_CLOSE, 1, '0, '0);
      send_word(OP_TICK, 1, '1, '1);
      send_word(OP_CLOSE, 10, '0, '0);
      send_word(OP_OPEN, 10, '0, '0);
      send_word(OP_CLOSE, 1, '0, '0);
      send_word(OP_TICK, 1, '0, '1);
      send_word(OP_OPEN, 11, '1, '0);
      send_word(OP_OPEN, 0, '0, '1);
      send_word(OP_TICK, 10, 10'h200, '0);
   endtask

   task automatic test_timeout_retry();
      apply_settings(10, 1, 1);
      send_word(OP_OPEN, 3, '0, '0);
      repeat (4) send_word(OP_TICK, 3, '0, '0);
      send_word(OP_CLOSE, 3, '0, '0);
      send_word(OP_TICK, 3, '0, 10'h004);
   endtask

   task automatic test_zero_timeout();
      apply_settings(10, 0, 0);
      send_word(OP_OPEN, 5, '0, '0);
      send_word(OP_TICK, 5, '1, '1);
      send_word(OP_OPEN, 5, '0, '0);
   endtask

   task automatic test_active_range();
      apply_settings(0, 5, 3);
      send_word(OP_OPEN, 1, '0, '0);
      send_word(OP_TICK, 1, '1, '1);
      apply_settings(15, 5, 3);
      send_word(OP_OPEN, 10, '0, '0);
      apply_settings(1, 5, 3);
      send_word(OP_OPEN, 2, '0, '0);
   endtask

   // The response side holds off for a long stretch while requests keep
   // coming back to back, so the block fills up and stalls its input.
   task automatic test_backpressure();
      apply_settings(10, 4, 2);
      hold_asked++;
      gaps_on = 1'b0;
      run_random(60, 1);
      gaps_on = 1'b1;
      wait_drained();
      run_random(40, 2);
   endtask

   task automatic test_random_settings();
      int act_set  [PHASES] = '{10, 1, 10, 5, 15, 0, 10, 3, 7};
      int tmo_set  [PHASES] = '{2, 1, 8, 3, 4, 5, 65535, 0, 6};
      int rty_set  [PHASES] = '{3, 0, 7, 2, 1, 3, 7, 0, 5};
      int dens_set [PHASES] = '{1, 2, 1, 1, 2, 3, 2, 1, 1};
      int p;
      for (p = 0; p < PHASES; p++) begin
         apply_settings(act_set[p], tmo_set[p], rty_set[p]);
         run_random(165, dens_set[p]);
      end
   endtask

   task automatic note_mismatch(string field, logic [15:0] exp, logic [15:0] got);
      n_mismatch++;
      if (n_mismatch <= REPORT_LIMIT)
         $display("Mismatch on word %0d, %s: expected 0x%0h, got 0x%0h",
                  n_checked, field, exp, got);
   endtask

   // Response checker.
   always @(posedge clock) begin
      gate_report_type got;
      gate_report_type exp;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = {rsp_chan.addressed_state, rsp_chan.accepted, rsp_chan.servo_open_mask,
                rsp_chan.moving_mask, rsp_chan.error_mask, rsp_chan.retry_mask};
         if (expected_reports.size() == 0) begin
            note_mismatch("unexpected word", '0, 16'(got.addressed_state));
         end else begin
            exp = expected_reports.pop_front();
            if (got.addressed_state !== exp.addressed_state)
               note_mismatch("addressed_state", 16'(exp.addressed_state),
                             16'(got.addressed_state));
            if (got.accepted !== exp.accepted)
               note_mismatch("accepted", 16'(exp.accepted), 16'(got.accepted));
            if (got.servo_open_mask !== exp.servo_open_mask)
               note_mismatch("servo_open_mask", 16'(exp.servo_open_mask),
                             16'(got.servo_open_mask));
            if (got.moving_mask !== exp.moving_mask)
               note_mismatch("moving_mask", 16'(exp.moving_mask), 16'(got.moving_mask));
            if (got.error_mask !== exp.error_mask)
               note_mismatch("error_mask", 16'(exp.error_mask), 16'(got.error_mask));
            if (got.retry_mask !== exp.retry_mask)
               note_mismatch("retry_mask", 16'(exp.retry_mask), 16'(got.retry_mask));
         end
         n_checked++;
      end
   end

   // Response side: stall modes change every so often, and a long hold-off
   // is counted here whenever a test asks for one.
   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         case (drain_mode)
            DRAIN_FREE:    rsp_chan.ready <= 1'b1;
            DRAIN_COIN:    rsp_chan.ready <= ($urandom_range(0, 1) == 1);
            DRAIN_PATTERN: rsp_chan.ready <= (mode_left % 5) != 0;
            default:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("Run did not finish in time.");
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.op              <= OP_QUERY;
      req_chan.compartment     <= '0;
      req_chan.open_switches   <= '0;
      req_chan.closed_switches <= '0;
      csr_chan.valid           <= 1'b0;
      csr_chan.index           <= REG_ACTIVE_COUNT;
      csr_chan.data            <= '0;
      for (int i = 0; i < COMPARTMENTS; i++) begin
         gate_code[i]   = CODE_CLOSED;
         move_ticks[i]  = '0;
         retry_count[i] = '0;
         servo_cmd[i]   = 1'b0;
      end
      cfg_active  = ACTIVE_RESET;
      cfg_timeout = TIMEOUT_RESET;
      cfg_retry   = RETRY_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_commands();
      test_timeout_retry();
      test_zero_timeout();
      test_active_range();
      test_backpressure();
      test_random_settings();
      wait_drained();

      $display("Sent %0d request words under %0d register settings, checked %0d responses.",
               n_sent, n_settings, n_checked);
      $display("%0d commands started a move and %0d ticks restarted a stuck move.",
               n_moves, n_retries);
      if (n_mismatch == 0 && expected_reports.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d responses missing.", n_mismatch,
                  expected_reports.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/gatr_pkg.sv
rtl/gatr_if.sv
rtl/gatr_csr.sv
rtl/gatr_cell.sv
rtl/gate_actuator_timeout_retry_fsm_core.sv
tb/testbench.sv
